/* sv/bdsu_pkg.sv */
// Package for the byte divider: operand width, item types and pipeline stage type.
// No dependencies; used by byte_divider_signed_unsigned_unit.
`timescale 1ns / 1ps
`default_nettype none

package bdsu_pkg;

    localparam int DATA_WIDTH = 8;
    localparam int SIGN_BIT   = DATA_WIDTH - 1;

    localparam logic [DATA_WIDTH-1:0] ONE_W  = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [DATA_WIDTH-1:0] ZERO_W = '0;

    typedef enum logic {
        REQ_UNSIGNED = 1'b0,
        REQ_SIGNED   = 1'b1
    } req_type_t;

    typedef struct packed {
        logic                  req_type;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } rsp_t;

    // One pipeline stage of the array divider.
    // nq holds unused dividend bits at the top and quotient bits at the bottom.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] nq;
        logic [DATA_WIDTH-1:0] dm;
        logic [DATA_WIDTH-1:0] n_raw;
        logic                  q_neg;
        logic                  r_neg;
        logic                  dz;
    } stage_t;

endpackage

`default_nettype wire

/* sv/byte_divider_signed_unsigned_unit.sv */
// An accepted item passes through stage registers 0 to DATA_WIDTH and then the output
// registers, which show its result with done high.
// Throughput: one item per cycle; busy is never raised and nothing stalls.
// Cost per stage: one DATA_WIDTH+1 bit subtract (one restoring step per stage).
// Reset: rst_n clears all stage valid bits and done; no item is in flight after reset.
// Results cannot be held off: each item's result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module byte_divider_signed_unsigned_unit
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bdsu_pkg::req_t req,
    output logic                done,
    output bdsu_pkg::rsp_t      rsp
);

    localparam int W   = bdsu_pkg::DATA_WIDTH;
    // Edges from acceptance to the edge that samples done.
    localparam int LAT = W + 2;

    // Stage 0 holds the operand magnitudes; stage k holds the state after k restoring steps.
    bdsu_pkg::stage_t stg_reg [0:W];
    logic             vld_reg [0:W];

    bdsu_pkg::rsp_t   rsp_reg;
    logic             done_reg;

    bdsu_pkg::stage_t stg0_next;
    bdsu_pkg::rsp_t   rsp_next;

    logic             accept;
    logic             n_neg;
    logic             d_neg;

    // Pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    //------------------------------------------------------------------
    // Entry stage: sign handling and magnitudes
    //------------------------------------------------------------------
    always_comb
    begin
        n_neg = (req.req_type == bdsu_pkg::REQ_SIGNED) && req.dividend[bdsu_pkg::SIGN_BIT];
        d_neg = (req.req_type == bdsu_pkg::REQ_SIGNED) && req.divisor[bdsu_pkg::SIGN_BIT];

        stg0_next.rem   = bdsu_pkg::ZERO_W;
        stg0_next.nq    = n_neg ? (~req.dividend + bdsu_pkg::ONE_W) : req.dividend;
        stg0_next.dm    = d_neg ? (~req.divisor + bdsu_pkg::ONE_W) : req.divisor;
        stg0_next.n_raw = req.dividend;
        stg0_next.q_neg = n_neg ^ d_neg;
        stg0_next.r_neg = n_neg;
        stg0_next.dz    = (req.divisor == bdsu_pkg::ZERO_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_reg[0] <= stg0_next;
        end
    end

    //------------------------------------------------------------------
    // Restoring steps, one quotient bit per stage, MSB first
    //------------------------------------------------------------------
    for (genvar gi = 1; gi <= W; gi++)
    begin : g_step
        bdsu_pkg::stage_t step_next;
        logic [W:0]       shifted;
        logic [W:0]       diff;

        always_comb
        begin
            shifted   = {stg_reg[gi-1].rem, stg_reg[gi-1].nq[W-1]};
            diff      = shifted - {1'b0, stg_reg[gi-1].dm};
            step_next = stg_reg[gi-1];
            // No borrow means the shifted partial remainder covers the divisor.
            if (!diff[W])
            begin
                step_next.rem = diff[W-1:0];
            end
            else
            begin
                step_next.rem = shifted[W-1:0];
            end
            step_next.nq = {stg_reg[gi-1].nq[W-2:0], ~diff[W]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[gi] <= 1'b0;
            end
            else
            begin
                vld_reg[gi] <= vld_reg[gi-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (vld_reg[gi-1])
            begin
                stg_reg[gi] <= step_next;
            end
        end
    end

    //------------------------------------------------------------------
    // Output stage: sign fix-up and divide-by-zero override
    //------------------------------------------------------------------
    always_comb
    begin
        if (stg_reg[W].dz)
        begin
            rsp_next.quotient  = bdsu_pkg::ZERO_W;
            rsp_next.remainder = stg_reg[W].n_raw;
        end
        else
        begin
            rsp_next.quotient  = stg_reg[W].q_neg ? (~stg_reg[W].nq + bdsu_pkg::ONE_W)
                                                  : stg_reg[W].nq;
            rsp_next.remainder = stg_reg[W].r_neg ? (~stg_reg[W].rem + bdsu_pkg::ONE_W)
                                                  : stg_reg[W].rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[W])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    // Every result traces back to an item accepted a fixed latency earlier.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching item");

    // Valid bits move one stage per cycle.
    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |=> vld_reg[1])
        else $error("valid bit lost in pipeline");

    // Divide by zero: quotient zero, remainder is the dividend.
    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(req.divisor, LAT) == bdsu_pkg::ZERO_W)) |->
        (rsp.quotient == bdsu_pkg::ZERO_W && rsp.remainder == $past(req.dividend, LAT)))
        else $error("divide-by-zero result wrong");

    // Unsigned mode with a nonzero divisor: remainder below the divisor.
    a_urem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(req.req_type, LAT) == bdsu_pkg::REQ_UNSIGNED)
              && ($past(req.divisor, LAT) != bdsu_pkg::ZERO_W)) |->
        (rsp.remainder < $past(req.divisor, LAT)))
        else $error("unsigned remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* sim/tb_byte_divider_signed_unsigned_unit.sv */
// Self-checking testbench for byte_divider_signed_unsigned_unit: signed and unsigned
// byte division through the pipelined divider, checked per item against a local predictor.
// Depends on bdsu_pkg and the divider RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_byte_divider_signed_unsigned_unit;

    localparam int W            = bdsu_pkg::DATA_WIDTH;
    localparam int N_RANDOM     = 1650;
    // Worst case with no handshake in either direction: reset, longest sender
    // gap and pipeline latency. Taken several times over.
    localparam int STALL_LIMIT  = 200;
    localparam int DRAIN_CYCLES = W + 4;

    typedef logic [W-1:0] byte_t;

    // One row of the directed table; fixed_ok marks rows whose result is typed in.
    typedef struct packed {
        bdsu_pkg::req_t item;
        bit             fixed_ok;
        bdsu_pkg::rsp_t fixed;
    } div_case_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bdsu_pkg::req_t req;
    logic           done;
    bdsu_pkg::rsp_t rsp;

    bdsu_pkg::rsp_t div_results_due[$];   // expected quotient/remainder, oldest first
    div_case_t      directed_cases[$];

    int mismatches;
    int items_sent;
    int results_seen;
    int signed_items;
    int zero_divisor_items;
    int quiet_cycles;

    byte_divider_signed_unsigned_unit i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: restoring shift-subtract division on magnitudes.
    // The carry out of the top remainder bit forces a subtract, so a
    // magnitude of 2^(W-1) still divides correctly.
    // ------------------------------------------------------------------
    function automatic bdsu_pkg::rsp_t trunc_divide(bdsu_pkg::req_t it);
        byte_t          n;
        byte_t          d;
        byte_t          nm;
        byte_t          dm;
        byte_t          q;
        byte_t          rm;
        logic           carry;
        logic           n_neg;
        logic           d_neg;
        bdsu_pkg::rsp_t res;
        n = it.dividend;
        d = it.divisor;
        // Divide by zero: quotient 0, remainder is the raw dividend in either mode.
        if (d == bdsu_pkg::ZERO_W)
        begin
            res.quotient  = bdsu_pkg::ZERO_W;
            res.remainder = n;
            return res;
        end
        n_neg = (it.req_type == bdsu_pkg::REQ_SIGNED) && n[bdsu_pkg::SIGN_BIT];
        d_neg = (it.req_type == bdsu_pkg::REQ_SIGNED) && d[bdsu_pkg::SIGN_BIT];
        nm    = n_neg ? bdsu_pkg::ZERO_W - n : n;
        dm    = d_neg ? bdsu_pkg::ZERO_W - d : d;
        q     = bdsu_pkg::ZERO_W;
        rm    = bdsu_pkg::ZERO_W;
        for (int i = W - 1; i >= 0; i--)
        begin
            carry = rm[W-1];
            rm    = {rm[W-2:0], nm[i]};
            if (carry || rm >= dm)
            begin
                rm   = rm - dm;
                q[i] = 1'b1;
            end
        end
        // Sign fix-up; -128 / -1 wraps back to -128 here.
        if (n_neg != d_neg)
            q = bdsu_pkg::ZERO_W - q;
        if (n_neg)
            rm = bdsu_pkg::ZERO_W - rm;
        res.quotient  = q;
        res.remainder = rm;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_case(input bdsu_pkg::req_type_t mode, input byte_t n, input byte_t d,
                            input bit fixed_ok, input byte_t q, input byte_t r);
        div_case_t c;
        c.item.req_type     = mode;
        c.item.dividend     = n;
        c.item.divisor      = d;
        c.fixed_ok          = fixed_ok;
        c.fixed.quotient    = q;
        c.fixed.remainder   = r;
        directed_cases.push_back(c);
    endtask

    // Operand mix: mostly uniform bytes, plus corners, small positives and
    // small negatives so the sign handling sees plenty of close calls.
    function automatic byte_t pick_operand();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: return 8'h00;
                    1: return 8'h01;
                    2: return 8'h7F;
                    3: return 8'h80;
                    4: return 8'h81;
                    5: return 8'hFE;
                    default: return 8'hFF;
                endcase
            end
            1: return byte_t'($urandom_range(0, 15));
            2: return byte_t'(8'hFF - $urandom_range(0, 15));
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Sender gap: start low, req filled with noise the block must ignore.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            start <= 1'b0;
            req   <= bdsu_pkg::req_t'({$urandom, $urandom});
            @(posedge clk);
        end
    endtask

    // Present one item and hold it until accepted (start high, busy low at an edge).
    // Returns on the accepting edge, so start can stay high for a back-to-back item.
    task automatic send_div(input bdsu_pkg::req_t it, input bdsu_pkg::rsp_t want);
        start <= 1'b1;
        req   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        div_results_due.push_back(want);
        items_sent++;
        if (it.req_type == bdsu_pkg::REQ_SIGNED)
            signed_items++;
        if (it.divisor == bdsu_pkg::ZERO_W)
            zero_divisor_items++;
    endtask

    // ------------------------------------------------------------------
    // Result checker and watchdog. Sampled at the edge, so it sees the
    // values from the cycle that the edge ends.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (div_results_due.size() == 0)
            begin
                report_mismatch($sformatf("result with no item pending: q 0x%02h r 0x%02h",
                                          rsp.quotient, rsp.remainder));
            end
            else
            begin
                bdsu_pkg::rsp_t want;
                want = div_results_due.pop_front();
                if (rsp.quotient !== want.quotient)
                    report_mismatch($sformatf("quotient: got 0x%02h, expected 0x%02h",
                                              rsp.quotient, want.quotient));
                if (rsp.remainder !== want.remainder)
                    report_mismatch($sformatf("remainder: got 0x%02h, expected 0x%02h",
                                              rsp.remainder, want.remainder));
            end
        end

        // Any handshake in either direction counts as progress.
        if ((start && !busy && rst_n) || (done && rst_n))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, div_results_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        bdsu_pkg::req_t it;
        bdsu_pkg::rsp_t want;
        int             burst_left;

        mismatches         = 0;
        items_sent         = 0;
        results_seen       = 0;
        signed_items       = 0;
        zero_divisor_items = 0;
        quiet_cycles       = 0;
        rst_n              = 1'b0;
        start              = 1'b0;
        req                = '0;

        // Directed table. Typed results are the ones readable at a glance;
        // rows with fixed_ok = 0 go to the predictor.
        // Unsigned: divide by zero, full-scale operands, alternating bit patterns.
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'h00, 8'h00, 1, 8'h00, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'hFF, 8'h00, 1, 8'h00, 8'hFF);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'hFF, 8'hFF, 1, 8'h01, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'hFF, 8'h01, 1, 8'hFF, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'h00, 8'hFF, 1, 8'h00, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'h01, 8'hFF, 1, 8'h00, 8'h01);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'h80, 8'h80, 1, 8'h01, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'hC8, 8'h07, 0, 8'h00, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'hAA, 8'h55, 0, 8'h00, 8'h00);
        add_case(bdsu_pkg::REQ_UNSIGNED, 8'h55, 8'hAA, 0, 8'h00, 8'h00);
        // Signed: most negative over minus one wraps, zero divisor keeps the raw byte.
        add_case(bdsu_pkg::REQ_SIGNED,   8'h80, 8'hFF, 1, 8'h80, 8'h00);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h80, 8'h00, 1, 8'h00, 8'h80);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h7F, 8'h00, 1, 8'h00, 8'h7F);
        // Most negative magnitude on either side.
        add_case(bdsu_pkg::REQ_SIGNED,   8'h80, 8'h01, 1, 8'h80, 8'h00);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h80, 8'h80, 1, 8'h01, 8'h00);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h7F, 8'h80, 1, 8'h00, 8'h7F);
        add_case(bdsu_pkg::REQ_SIGNED,   8'hFF, 8'h80, 1, 8'h00, 8'hFF);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h7F, 8'hFF, 1, 8'h81, 8'h00);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h7F, 8'h7F, 1, 8'h01, 8'h00);
        // Truncation toward zero, remainder takes the dividend sign: +-7 / +-2.
        add_case(bdsu_pkg::REQ_SIGNED,   8'hF9, 8'h02, 1, 8'hFD, 8'hFF);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h07, 8'hFE, 1, 8'hFD, 8'h01);
        add_case(bdsu_pkg::REQ_SIGNED,   8'hF9, 8'hFE, 1, 8'h03, 8'hFF);
        add_case(bdsu_pkg::REQ_SIGNED,   8'h55, 8'hAA, 0, 8'h00, 8'h00);
        add_case(bdsu_pkg::REQ_SIGNED,   8'hAA, 8'h55, 0, 8'h00, 8'h00);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, mostly back to back with an occasional gap.
        foreach (directed_cases[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 4));
            it   = directed_cases[i].item;
            want = directed_cases[i].fixed_ok ? directed_cases[i].fixed : trunc_divide(it);
            send_div(it, want);
        end

        // Random part in bursts: mostly short bursts with gaps of varying
        // length, now and then a long stretch with no idling at all.
        burst_left = 0;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (burst_left == 0)
            begin
                idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                         : $urandom_range(1, 30);
            end
            it.req_type = ($urandom_range(0, 1) == 0) ? bdsu_pkg::REQ_UNSIGNED
                                                      : bdsu_pkg::REQ_SIGNED;
            it.dividend = pick_operand();
            it.divisor  = ($urandom_range(0, 19) == 0) ? bdsu_pkg::ZERO_W : pick_operand();
            send_div(it, trunc_divide(it));
            burst_left--;
        end
        idle_cycles(1);

        // Drain: wait for every result (watchdog bounds this), then a few more
        // cycles to catch anything extra coming out of the pipeline.
        while (div_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items (%0d signed, %0d with zero divisor), %0d results checked",
                 items_sent, signed_items, zero_divisor_items, results_seen);
        $display("Directed corners: %0d, mismatches: %0d", directed_cases.size(), mismatches);
        if (mismatches == 0 && div_results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
